// File: rtl/xasp_pkg.sv
// Package for the XOR archive stream parser: state, result and command types,
// plus fixed constants of the archive format. No dependencies.
`default_nettype none
package xasp_pkg;

    localparam logic [7:0]  KEY_RESET  = 8'hF7;
    localparam logic [7:0]  FLAG_END   = 8'h80;
    localparam logic [63:0] MAGIC_WORD = 64'h0000_0000_BAC0_4AC0;

    typedef enum logic [3:0] {
        ST_MAGIC,
        ST_VERSION,
        ST_FLAG,
        ST_NAMELEN,
        ST_NAME,
        ST_SIZE,
        ST_TIME,
        ST_BODY,
        ST_DONE,
        ST_ERROR,
        ST_SEEK_RD,
        ST_SEEK_CHK,
        ST_FIN_ERR
    } state_t;

    typedef enum logic [2:0] {
        KIND_NAME = 3'd0,
        KIND_SIZE = 3'd1,
        KIND_TIME = 3'd2,
        KIND_BODY = 3'd3,
        KIND_ERR  = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        ERR_MAGIC   = 2'd0,
        ERR_VERSION = 2'd1,
        ERR_BROKEN  = 2'd2,
        ERR_FULL    = 2'd3
    } err_t;

    typedef enum logic [1:0] {
        SRC_BYTE,
        SRC_ASM,
        SRC_ERR
    } src_t;

    typedef enum logic [1:0] {
        IDX_RC,
        IDX_CUR,
        IDX_NONE
    } idx_sel_t;

    // One result item as held in the output queue.
    typedef struct packed {
        kind_t       kind;
        logic [63:0] payload;
        logic [7:0]  idx;
        logic        eoi;
    } res_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     acc;
        logic     fld_clr;
        logic     fc_load;
        logic     fc_dec;
        logic     tbl_wr;
        logic     rc_inc;
        logic     cur_zero;
        logic     cur_inc;
        logic     bl_load;
        logic     bl_clr;
        logic     bl_dec;
        logic     rd;
        logic     clear_all;
        logic     push;
        kind_t    kind;
        src_t     src;
        idx_sel_t idx_sel;
        logic     eoi;
        err_t     err;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic q_space;
        logic d_is_end;
        logic d_is_zero;
        logic magic_ok;
        logic ver_ok;
        logic fc_is3;
        logic fc_is7;
        logic fc_le1;
        logic rc_full;
        logic bl_le1;
        logic cur_end;
        logic ram_zero;
    } dp_status_t;

endpackage
`default_nettype wire

// File: rtl/xor_archive_stream_parser_top.sv
// Top level of the XOR archive stream parser: joins controller and datapath.
// Depends on xasp_pkg, xasp_ctrl, xasp_dp (and through it xasp_ram).
//
//  channel  | signals                          | content
//  ---------+----------------------------------+-----------------------------------
//  s_       | tvalid tready tdata[7:0] tlast   | raw archive byte; tlast = final byte
//  m_       | tvalid tready tdata[71:0]        | payload[63:0], file_index[71:64]
//           | tuser[2:0] tlast                 | tuser = kind; tlast = end of item
//  cfg_     | valid ready data[7:0]            | XOR key, always ready
//
// One byte is taken per cycle while parsing the header and streaming file bodies, as
// long as the result queue has space. Leaving a file body, or taking the end-of-header
// flag, starts a scan of the size table with input held: each table entry looked at
// passes a read state and a check state (registered RAM read), and the scan ends in
// the read state once it runs past the last record, so each zero-size file skipped
// adds a read and a check before the next body byte. A final byte that leaves the
// archive unfinished moves to a state that pushes the broken-stream error item and waits
// there while the result queue is full. Results sit in a two-entry queue, so a stalled
// consumer holds up input only once both entries are full.
// Reset clears all control state and restores the key to F7; the size table
// keeps no reset value, since only entries already written are ever read.
`default_nettype none
module xor_archive_stream_parser_top
    import xasp_pkg::*;
#(
    parameter int MAX_RECORDS = 256
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration: XOR key
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_data,     // [7:0] xor_key
    // archive byte in
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,      // [7:0] raw_byte
    input  wire logic        s_tlast,      // final_byte
    // result item out
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata,      // [63:0] payload, [71:64] file_index
    output logic [2:0]       m_tuser,      // [2:0] kind
    output logic             m_tlast       // end_of_item
);

    dp_cmd_t    cmd;
    dp_status_t st;

    // The key takes a write on any cycle; the user must send writes only while idle.
    assign cfg_ready = 1'b1;

    xasp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    xasp_dp #(
        .MAX_RECORDS (MAX_RECORDS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .st        (st),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule
`default_nettype wire

// File: rtl/xasp_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none
module xasp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                                   clk,
    input  wire logic                                   wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                       wr_data,
    input  wire logic                                   rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

// File: rtl/xasp_dp.sv
// Datapath of the archive parser: key, field assembler, counters, size table
// and two-entry result queue. Depends on xasp_pkg and xasp_ram.
`default_nettype none
module xasp_dp
    import xasp_pkg::*;
#(
    parameter int MAX_RECORDS = 256
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    input  wire logic [7:0]  cfg_data,
    input  wire logic [7:0]  s_tdata,
    input  wire dp_cmd_t     cmd,
    output dp_status_t       st,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata,
    output logic [2:0]       m_tuser,
    output logic             m_tlast
);

    localparam int AW  = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
    localparam int RCW = $clog2(MAX_RECORDS + 1);

    logic [7:0]     key_reg, key_next;
    logic [7:0]     fc_reg, fc_next;
    logic [63:0]    asm_reg, asm_next;
    logic [RCW-1:0] rc_reg, rc_next;
    logic [RCW-1:0] cur_reg, cur_next;
    logic [31:0]    bl_reg, bl_next;
    res_t           q0_reg, q0_next, q1_reg, q1_next;
    logic [1:0]     qcnt_reg, qcnt_next;

    logic [7:0]      d;
    logic [63:0]     asm_new;
    logic [31:0]     rd_data;
    logic [RCW+7:0]  rc_ext, cur_ext;
    res_t            res;
    logic            pop;

    assign d       = s_tdata ^ key_reg;
    assign asm_new = asm_reg | ({56'b0, d} << {fc_reg[2:0], 3'b000});
    assign rc_ext  = {8'b0, rc_reg};
    assign cur_ext = {8'b0, cur_reg};

    xasp_ram #(
        .WIDTH (32),
        .DEPTH (MAX_RECORDS)
    ) u_size_tbl (
        .clk     (clk),
        .wr_en   (cmd.tbl_wr),
        .wr_addr (rc_reg[AW-1:0]),
        .wr_data (asm_new[31:0]),
        .rd_en   (cmd.rd),
        .rd_addr (cur_reg[AW-1:0]),
        .rd_data (rd_data)
    );

    always_comb
    begin
        st.q_space   = (qcnt_reg != 2'd2);
        st.d_is_end  = (d == FLAG_END);
        st.d_is_zero = (d == 8'd0);
        st.magic_ok  = (asm_new == MAGIC_WORD);
        st.ver_ok    = (asm_new == 64'd0);
        st.fc_is3    = (fc_reg == 8'd3);
        st.fc_is7    = (fc_reg == 8'd7);
        st.fc_le1    = (fc_reg <= 8'd1);
        st.rc_full   = (rc_reg >= RCW'(MAX_RECORDS));
        st.bl_le1    = (bl_reg <= 32'd1);
        st.cur_end   = (cur_reg >= rc_reg);
        st.ram_zero  = (rd_data == 32'd0);
    end

    // Build the result being pushed.
    always_comb
    begin
        res.kind = cmd.kind;
        res.eoi  = cmd.eoi;
        unique case (cmd.src)
            SRC_BYTE: res.payload = {56'b0, d};
            SRC_ASM:  res.payload = asm_new;
            SRC_ERR:  res.payload = {62'b0, cmd.err};
            default:  res.payload = 64'd0;
        endcase
        unique case (cmd.idx_sel)
            IDX_RC:   res.idx = rc_ext[7:0];
            IDX_CUR:  res.idx = cur_ext[7:0];
            IDX_NONE: res.idx = 8'd0;
            default:  res.idx = 8'd0;
        endcase
    end

    always_comb
    begin
        key_next = cfg_valid ? cfg_data : key_reg;

        fc_next  = fc_reg;
        asm_next = asm_reg;
        rc_next  = rc_reg;
        cur_next = cur_reg;
        bl_next  = bl_reg;

        if (cmd.clear_all)
        begin
            fc_next  = 8'd0;
            asm_next = 64'd0;
            rc_next  = '0;
            cur_next = '0;
            bl_next  = 32'd0;
        end
        else
        begin
            priority if (cmd.fld_clr)
            begin
                fc_next  = 8'd0;
                asm_next = 64'd0;
            end
            else if (cmd.acc)
            begin
                fc_next  = fc_reg + 8'd1;
                asm_next = asm_new;
            end
            else if (cmd.fc_load)
            begin
                fc_next = d;
            end
            else if (cmd.fc_dec)
            begin
                fc_next = fc_reg - 8'd1;
            end

            if (cmd.rc_inc)
            begin
                rc_next = rc_reg + RCW'(1);
            end

            priority if (cmd.cur_zero)
            begin
                cur_next = '0;
            end
            else if (cmd.cur_inc)
            begin
                cur_next = cur_reg + RCW'(1);
            end

            priority if (cmd.bl_load)
            begin
                bl_next = rd_data;
            end
            else if (cmd.bl_clr)
            begin
                bl_next = 32'd0;
            end
            else if (cmd.bl_dec)
            begin
                bl_next = bl_reg - 32'd1;
            end
        end
    end

    // Two-entry result queue; head is q0.
    assign pop = (qcnt_reg != 2'd0) && m_tready;

    always_comb
    begin
        q0_next   = q0_reg;
        q1_next   = q1_reg;
        qcnt_next = qcnt_reg;
        unique case ({cmd.push, pop})
            2'b10:
            begin
                if (qcnt_reg == 2'd0)
                begin
                    q0_next = res;
                end
                else
                begin
                    q1_next = res;
                end
                qcnt_next = qcnt_reg + 2'd1;
            end
            2'b01:
            begin
                q0_next   = q1_reg;
                qcnt_next = qcnt_reg - 2'd1;
            end
            2'b11:
            begin
                if (qcnt_reg == 2'd1)
                begin
                    q0_next = res;
                end
                else
                begin
                    q0_next = q1_reg;
                    q1_next = res;
                end
            end
            default:
            begin
                qcnt_next = qcnt_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg  <= KEY_RESET;
            fc_reg   <= 8'd0;
            asm_reg  <= 64'd0;
            rc_reg   <= '0;
            cur_reg  <= '0;
            bl_reg   <= 32'd0;
            qcnt_reg <= 2'd0;
        end
        else
        begin
            key_reg  <= key_next;
            fc_reg   <= fc_next;
            asm_reg  <= asm_next;
            rc_reg   <= rc_next;
            cur_reg  <= cur_next;
            bl_reg   <= bl_next;
            qcnt_reg <= qcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q0_reg <= q0_next;
        q1_reg <= q1_next;
    end

    assign m_tvalid = (qcnt_reg != 2'd0);
    assign m_tdata  = {q0_reg.idx, q0_reg.payload};
    assign m_tuser  = q0_reg.kind;
    assign m_tlast  = q0_reg.eoi;

    a_qcnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        qcnt_reg != 2'd3)
        else $error("result queue count out of range");

    a_push_space: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> (qcnt_reg != 2'd2) || m_tready)
        else $error("result pushed into a full queue");

    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear_all |=> (rc_reg == '0) && (cur_reg == '0))
        else $error("clear left record state behind");

    a_cur_le_rc: assert property (@(posedge clk) disable iff (!rst_n)
        cur_reg <= rc_reg)
        else $error("current file beyond record count");

endmodule
`default_nettype wire

// File: rtl/xasp_ctrl.sv
// Controller of the archive parser: parse phase state machine, zero-size skip
// sequencing and end-of-archive handling. Depends on xasp_pkg.
`default_nettype none
module xasp_ctrl
    import xasp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    input  wire logic       s_tlast,
    output logic            s_tready,
    input  wire dp_status_t st,
    output dp_cmd_t         cmd
);

    state_t state_reg, state_next, phase_nx;
    logic   fin_reg, fin_next;
    logic   parse_st;
    logic   take;

    assign parse_st = (state_reg == ST_MAGIC)   || (state_reg == ST_VERSION) ||
                      (state_reg == ST_FLAG)    || (state_reg == ST_NAMELEN) ||
                      (state_reg == ST_NAME)    || (state_reg == ST_SIZE)    ||
                      (state_reg == ST_TIME)    || (state_reg == ST_BODY)    ||
                      (state_reg == ST_DONE)    || (state_reg == ST_ERROR);
    assign s_tready = parse_st && st.q_space;
    assign take     = s_tready && s_tvalid;

    always_comb
    begin
        cmd        = '0;
        cmd.kind   = KIND_ERR;
        cmd.src    = SRC_ERR;
        cmd.idx_sel = IDX_NONE;
        cmd.err    = ERR_MAGIC;
        state_next = state_reg;
        phase_nx   = state_reg;
        fin_next   = fin_reg;

        unique case (state_reg)
            ST_MAGIC, ST_VERSION:
            begin
                if (take)
                begin
                    cmd.acc = 1'b1;
                    if (st.fc_is3)
                    begin
                        if (state_reg == ST_MAGIC)
                        begin
                            if (st.magic_ok)
                            begin
                                cmd.fld_clr = 1'b1;
                                phase_nx    = ST_VERSION;
                            end
                            else
                            begin
                                cmd.push = 1'b1;
                                cmd.err  = ERR_MAGIC;
                                phase_nx = ST_ERROR;
                            end
                        end
                        else
                        begin
                            if (st.ver_ok)
                            begin
                                phase_nx = ST_FLAG;
                            end
                            else
                            begin
                                cmd.push = 1'b1;
                                cmd.err  = ERR_VERSION;
                                phase_nx = ST_ERROR;
                            end
                        end
                    end
                end
            end
            ST_FLAG:
            begin
                if (take)
                begin
                    priority if (st.d_is_end)
                    begin
                        cmd.cur_zero = 1'b1;
                        phase_nx     = ST_SEEK_RD;
                    end
                    else if (st.rc_full)
                    begin
                        cmd.push = 1'b1;
                        cmd.err  = ERR_FULL;
                        phase_nx = ST_ERROR;
                    end
                    else
                    begin
                        phase_nx = ST_NAMELEN;
                    end
                end
            end
            ST_NAMELEN:
            begin
                if (take)
                begin
                    if (st.d_is_zero)
                    begin
                        cmd.fld_clr = 1'b1;
                        phase_nx    = ST_SIZE;
                    end
                    else
                    begin
                        cmd.fc_load = 1'b1;
                        phase_nx    = ST_NAME;
                    end
                end
            end
            ST_NAME:
            begin
                if (take)
                begin
                    cmd.push    = 1'b1;
                    cmd.kind    = KIND_NAME;
                    cmd.src     = SRC_BYTE;
                    cmd.idx_sel = IDX_RC;
                    cmd.eoi     = st.fc_le1;
                    if (st.fc_le1)
                    begin
                        cmd.fld_clr = 1'b1;
                        phase_nx    = ST_SIZE;
                    end
                    else
                    begin
                        cmd.fc_dec = 1'b1;
                    end
                end
            end
            ST_SIZE:
            begin
                if (take)
                begin
                    cmd.acc = 1'b1;
                    if (st.fc_is3)
                    begin
                        cmd.tbl_wr  = 1'b1;
                        cmd.push    = 1'b1;
                        cmd.kind    = KIND_SIZE;
                        cmd.src     = SRC_ASM;
                        cmd.idx_sel = IDX_RC;
                        cmd.fld_clr = 1'b1;
                        phase_nx    = ST_TIME;
                    end
                end
            end
            ST_TIME:
            begin
                if (take)
                begin
                    cmd.acc = 1'b1;
                    if (st.fc_is7)
                    begin
                        cmd.push    = 1'b1;
                        cmd.kind    = KIND_TIME;
                        cmd.src     = SRC_ASM;
                        cmd.idx_sel = IDX_RC;
                        cmd.rc_inc  = 1'b1;
                        cmd.fld_clr = 1'b1;
                        phase_nx    = ST_FLAG;
                    end
                end
            end
            ST_BODY:
            begin
                if (take)
                begin
                    cmd.push    = 1'b1;
                    cmd.kind    = KIND_BODY;
                    cmd.src     = SRC_BYTE;
                    cmd.idx_sel = IDX_CUR;
                    cmd.eoi     = st.bl_le1;
                    if (st.bl_le1)
                    begin
                        cmd.cur_inc = 1'b1;
                        phase_nx    = ST_SEEK_RD;
                    end
                    else
                    begin
                        cmd.bl_dec = 1'b1;
                    end
                end
            end
            ST_DONE, ST_ERROR:
            begin
                phase_nx = state_reg;
            end
            ST_SEEK_RD:
            begin
                if (st.cur_end)
                begin
                    cmd.bl_clr = 1'b1;
                    if (fin_reg)
                    begin
                        cmd.clear_all = 1'b1;
                        fin_next      = 1'b0;
                        state_next    = ST_MAGIC;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
                else
                begin
                    cmd.rd     = 1'b1;
                    state_next = ST_SEEK_CHK;
                end
            end
            ST_SEEK_CHK:
            begin
                if (st.ram_zero)
                begin
                    cmd.cur_inc = 1'b1;
                    state_next  = ST_SEEK_RD;
                end
                else
                begin
                    cmd.bl_load = 1'b1;
                    fin_next    = 1'b0;
                    state_next  = fin_reg ? ST_FIN_ERR : ST_BODY;
                end
            end
            ST_FIN_ERR:
            begin
                if (st.q_space)
                begin
                    cmd.push      = 1'b1;
                    cmd.err       = ERR_BROKEN;
                    cmd.clear_all = 1'b1;
                    state_next    = ST_MAGIC;
                end
            end
            default:
            begin
                state_next = ST_MAGIC;
            end
        endcase

        // Resolve the end-of-archive marker once the item's own step is known.
        if (take)
        begin
            if (phase_nx == ST_SEEK_RD)
            begin
                fin_next   = s_tlast;
                state_next = ST_SEEK_RD;
            end
            else if (!s_tlast)
            begin
                state_next = phase_nx;
            end
            else if ((phase_nx == ST_DONE) || (phase_nx == ST_ERROR))
            begin
                cmd.clear_all = 1'b1;
                state_next    = ST_MAGIC;
            end
            else
            begin
                state_next = ST_FIN_ERR;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_MAGIC;
            fin_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fin_reg   <= fin_next;
        end
    end

endmodule
`default_nettype wire

// File: verif/xor_archive_stream_parser_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for xor_archive_stream_parser_top: builds archives, encodes them
// with the current key and checks every result item against a byte-level predictor.
// Depends on xasp_pkg and the parser RTL only.
module xor_archive_stream_parser_top_tb;
    import xasp_pkg::*;

    localparam int RECORD_SLOTS = 256;
    localparam int SCAN_SETTLE  = 1200;   // covers a full size-table scan with margin
    localparam int ITEM_TARGET  = 1350;
    localparam int HOLD_CYCLES  = 300;

    // Predicts the parser result by result and holds the results still owed by the block.
    class archive_scoreboard;
        logic [7:0]  key;
        state_t      pstate;
        int          cnt;
        logic [63:0] gather;
        int          n_records;
        logic [31:0] sizes [RECORD_SLOTS];
        int          file_no;
        logic [31:0] remaining;
        res_t        awaited [$];
        int          mismatches;

        function new();
            key = KEY_RESET;
            mismatches = 0;
            restart();
        endfunction

        function void restart();
            pstate = ST_MAGIC;
            cnt = 0;
            gather = '0;
            n_records = 0;
            file_no = 0;
            remaining = '0;
        endfunction

        function void set_key(logic [7:0] k);
            key = k;
        endfunction

        function void await_result(kind_t k, logic [63:0] p, int i, logic e);
            res_t r;
            r.kind = k;
            r.payload = p;
            r.idx = i[7:0];
            r.eoi = e;
            awaited.push_back(r);
        endfunction

        function void begin_field(state_t nxt);
            pstate = nxt;
            cnt = 0;
            gather = '0;
        endfunction

        // Skip zero-size files from the given record onwards.
        function void next_file(int start);
            int i;
            i = start;
            while (i < n_records && sizes[i] == 0)
                i++;
            file_no = i;
            if (i < n_records)
            begin
                remaining = sizes[i];
                pstate = ST_BODY;
            end
            else
            begin
                remaining = '0;
                pstate = ST_DONE;
            end
        endfunction

        function void note_byte(logic [7:0] raw, logic fin);
            logic [7:0] d;
            bit         errd;
            d = raw ^ key;
            errd = 0;
            case (pstate)
                ST_MAGIC, ST_VERSION:
                begin
                    gather |= 64'(d) << (8 * (cnt % 4));
                    cnt++;
                    if (cnt >= 4)
                    begin
                        if (pstate == ST_MAGIC && gather != MAGIC_WORD)
                        begin
                            await_result(KIND_ERR, {62'd0, ERR_MAGIC}, 0, 1'b0);
                            errd = 1;
                            pstate = ST_ERROR;
                        end
                        else if (pstate == ST_MAGIC)
                            begin_field(ST_VERSION);
                        else if (gather != '0)
                        begin
                            await_result(KIND_ERR, {62'd0, ERR_VERSION}, 0, 1'b0);
                            errd = 1;
                            pstate = ST_ERROR;
                        end
                        else
                            pstate = ST_FLAG;
                    end
                end
                ST_FLAG:
                begin
                    if (d == FLAG_END)
                        next_file(0);
                    else if (n_records >= RECORD_SLOTS)
                    begin
                        await_result(KIND_ERR, {62'd0, ERR_FULL}, 0, 1'b0);
                        errd = 1;
                        pstate = ST_ERROR;
                    end
                    else
                        pstate = ST_NAMELEN;
                end
                ST_NAMELEN:
                begin
                    if (d == 8'h00)
                        begin_field(ST_SIZE);
                    else
                    begin
                        cnt = d;
                        pstate = ST_NAME;
                    end
                end
                ST_NAME:
                begin
                    await_result(KIND_NAME, 64'(d), n_records, cnt <= 1);
                    if (cnt <= 1)
                        begin_field(ST_SIZE);
                    else
                        cnt--;
                end
                ST_SIZE:
                begin
                    gather |= 64'(d) << (8 * (cnt % 4));
                    cnt++;
                    if (cnt >= 4)
                    begin
                        if (n_records < RECORD_SLOTS)
                            sizes[n_records] = gather[31:0];
                        await_result(KIND_SIZE, gather, n_records, 1'b0);
                        begin_field(ST_TIME);
                    end
                end
                ST_TIME:
                begin
                    gather |= 64'(d) << (8 * (cnt % 8));
                    cnt++;
                    if (cnt >= 8)
                    begin
                        await_result(KIND_TIME, gather, n_records, 1'b0);
                        n_records++;
                        begin_field(ST_FLAG);
                    end
                end
                ST_BODY:
                begin
                    if (remaining <= 1)
                    begin
                        await_result(KIND_BODY, 64'(d), file_no, 1'b1);
                        next_file(file_no + 1);
                    end
                    else
                    begin
                        await_result(KIND_BODY, 64'(d), file_no, 1'b0);
                        remaining--;
                    end
                end
                default: ;
            endcase
            // the last byte closes the archive, flagging it broken if it is unfinished
            if (fin)
            begin
                if (!errd && pstate != ST_DONE && pstate != ST_ERROR)
                    await_result(KIND_ERR, {62'd0, ERR_BROKEN}, 0, 1'b0);
                restart();
            end
        endfunction

        function void complain(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s", $time, msg);
        endfunction

        function void check_result(logic [2:0] kind, logic [63:0] payload, logic [7:0] idx,
                                   logic eoi);
            res_t want;
            if (awaited.size() == 0)
            begin
                complain($sformatf("unexpected result: kind %0d payload %h index %0d last %b",
                                   kind, payload, idx, eoi));
                return;
            end
            want = awaited.pop_front();
            if (kind !== want.kind || payload !== want.payload || idx !== want.idx
                || eoi !== want.eoi)
                complain($sformatf({"result mismatch: expected kind %0d payload %h index %0d ",
                                    "last %b, got kind %0d payload %h index %0d last %b"},
                                   want.kind, want.payload, want.idx, want.eoi,
                                   kind, payload, idx, eoi));
        endfunction

        function int pending();
            return awaited.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_data = 8'h00;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;      // [7:0] raw_byte
    logic        s_tlast = 1'b0;       // final_byte
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;              // [63:0] payload, [71:64] file_index
    logic [2:0]  m_tuser;              // [2:0] kind
    logic        m_tlast;              // end_of_item

    archive_scoreboard sb = new();

    logic [7:0] arch_bytes [$];        // decoded archive under construction
    logic [7:0] cur_key = KEY_RESET;   // key the stimulus is currently encoded with
    int         burst_left = 0;
    bit         hold_ask = 1'b0;       // asks the receiver for one long stall
    int         hold_left = 0;
    int         rx_mode = 0;
    int         rx_left = 0;

    xor_archive_stream_parser_top #(
        .MAX_RECORDS (RECORD_SLOTS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Abort a run that hangs.
    initial
    begin
        #10ms;
        $display("tb: failure");
        $finish;
    end

    // Observe all three channels at the edge: note the key, predict on every accepted byte,
    // check every accepted result against the oldest one owed.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sb.set_key(cfg_data);
            if (s_tvalid && s_tready)
                sb.note_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
                sb.check_result(m_tuser, m_tdata[63:0], m_tdata[71:64], m_tlast);
        end
    end

    // Receiver: switch between always-ready, light and heavy stalling; honour a long hold
    // when asked, so the output queue fills and the parser stalls its input.
    always @(posedge clk)
    begin
        if (hold_ask)
        begin
            hold_ask = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            if (rx_left == 0)
            begin
                rx_mode = $urandom_range(0, 2);
                rx_left = $urandom_range(20, 200);
            end
            rx_left--;
            case (rx_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= ($urandom_range(0, 3) != 0);
                default: m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Block until every predicted result has been taken.
    task automatic wait_for_results();
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // Offer one item and hold it until taken; rest between bursts, and now and then
    // pause until the parser has delivered everything owed.
    task automatic send_byte(input logic [7:0] raw, input logic fin);
        if (burst_left == 0 || $urandom_range(0, 299) == 0)
        begin
            s_tvalid <= 1'b0;
            if (burst_left == 0)
            begin
                repeat ($urandom_range(1, 8)) @(posedge clk);
                burst_left = ($urandom_range(0, 4) == 0) ? 200 : $urandom_range(1, 24);
            end
            else
                wait_for_results();
        end
        s_tvalid <= 1'b1;
        s_tdata  <= raw;
        s_tlast  <= fin;
        do
            @(posedge clk);
        while (!s_tready);
        burst_left--;
    endtask

    // Encode and send the first cut bytes of the archive; the last one closes it.
    task automatic send_archive(input int cut);
        for (int i = 0; i < cut; i++)
            send_byte(arch_bytes[i] ^ cur_key, i == cut - 1);
    endtask

    // Change the key only once the parser is idle, including any table scan.
    task automatic write_key(input logic [7:0] k);
        s_tvalid <= 1'b0;
        wait_for_results();
        repeat (SCAN_SETTLE) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= k;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        cur_key = k;
    endtask

    task automatic push_le(input logic [63:0] v, input int n);
        for (int i = 0; i < n; i++)
            arch_bytes.push_back(v[8 * i +: 8]);
    endtask

    // Build a well-formed decoded archive: header, nrec records, closing flag, bodies.
    // Without close_header the closing flag is an ordinary record flag instead.
    task automatic build_archive(input int nrec, input int max_size, input int zero_pct,
                                 input int max_name, input bit close_header);
        int          total;
        int          nlen;
        logic [31:0] sz;
        logic [7:0]  flag;
        total = 0;
        arch_bytes.delete();
        push_le(MAGIC_WORD, 4);
        push_le(64'd0, 4);
        for (int r = 0; r < nrec; r++)
        begin
            flag = 8'($urandom);
            if (flag == FLAG_END)
                flag = 8'h00;
            arch_bytes.push_back(flag);
            if (max_name >= 4 && $urandom_range(0, 39) == 0)
                nlen = $urandom_range(0, 255);
            else
                nlen = $urandom_range(0, max_name);
            arch_bytes.push_back(nlen[7:0]);
            repeat (nlen) arch_bytes.push_back(8'($urandom));
            sz = ($urandom_range(0, 99) < zero_pct) ? 32'd0 : $urandom_range(1, max_size);
            push_le(64'(sz), 4);
            total += sz;
            push_le({$urandom, $urandom}, 8);
        end
        flag = 8'($urandom);
        if (flag == FLAG_END)
            flag = 8'h7F;
        arch_bytes.push_back(close_header ? FLAG_END : flag);
        repeat (total) arch_bytes.push_back(8'($urandom));
    endtask

    initial
    begin
        logic [7:0] keys [4];
        int         sent;
        int         cut;
        int         r;
        int         pos;
        bit         held;

        held = 1'b0;
        keys[0] = 8'h00;
        keys[1] = 8'hFF;
        keys[2] = 8'($urandom);
        keys[3] = 8'($urandom);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, reset key: final byte on the very first byte, bad magic closed on
        // its last byte, bad version followed by an ignored byte, and an empty archive.
        arch_bytes = '{8'hC0};
        send_archive(1);
        arch_bytes = '{8'hC0, 8'h4A, 8'hC0, 8'hBB};
        send_archive(4);
        arch_bytes = '{8'hC0, 8'h4A, 8'hC0, 8'hBA, 8'h00, 8'h00, 8'h00, 8'h01, 8'h5A};
        send_archive(9);
        arch_bytes = '{8'hC0, 8'h4A, 8'hC0, 8'hBA, 8'h00, 8'h00, 8'h00, 8'h00, FLAG_END};
        send_archive(9);

        for (int c = 0; c < 4; c++)
        begin
            write_key(keys[c]);
            sent = 0;
            if (c == 2)
            begin
                // Many mostly empty files: long runs of zero-size skips between bodies.
                build_archive(24, 3, 90, 0, 1'b1);
                send_archive(arch_bytes.size());
                sent += arch_bytes.size();
            end
            while (sent < ITEM_TARGET / 4)
            begin
                r = $urandom_range(0, 99);
                build_archive($urandom_range(0, 5), 6, 30, 4, 1'b1);
                cut = arch_bytes.size();
                if (r < 55)
                begin
                    // complete archive, sometimes with trailing bytes to be ignored
                    if (!held || $urandom_range(0, 11) == 0)
                    begin
                        hold_ask = 1'b1;
                        held = 1'b1;
                    end
                    if ($urandom_range(0, 2) == 0)
                        repeat ($urandom_range(1, 4)) arch_bytes.push_back(8'($urandom));
                    cut = arch_bytes.size();
                end
                else if (r < 75)
                    cut = $urandom_range(1, cut);
                else if (r < 87)
                begin
                    // corrupt one bit of the magic or the version
                    pos = $urandom_range(0, 7);
                    arch_bytes[pos] = arch_bytes[pos] ^ (8'h01 << $urandom_range(0, 7));
                    if ($urandom_range(0, 1) == 0)
                        cut = $urandom_range(1, cut);
                end
                else
                begin
                    // valid header followed by noise: random records, flags and sizes
                    arch_bytes = arch_bytes[0:7];
                    repeat ($urandom_range(8, 60)) arch_bytes.push_back(8'($urandom));
                    cut = arch_bytes.size();
                end
                send_archive(cut);
                sent += cut;
            end
        end

        // Drain, then give a trailing scan time to show up any stray result.
        s_tvalid <= 1'b0;
        wait_for_results();
        repeat (SCAN_SETTLE) @(posedge clk);
        if (sb.pending() != 0)
            sb.complain($sformatf("%0d expected results never arrived", sb.pending()));
        if (sb.mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// File: files.f
rtl/xasp_pkg.sv
rtl/xasp_ram.sv
rtl/xasp_dp.sv
rtl/xasp_ctrl.sv
rtl/xor_archive_stream_parser_top.sv
verif/xor_archive_stream_parser_top_tb.sv
